// File: hdl/assert_macros.svh
// Assertion macros used by the pixel generator back end.
// Depends on nothing; the SYNTH macro empties every body.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define PTPG_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define PTPG_NEVER(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define PTPG_ASSERT(label, clk, rst, prop, msg)
`define PTPG_NEVER(label, clk, rst, expr, msg)
`endif
`endif

// File: hdl/ptpg_pkg.sv
// Types, constants and font tables of the proportional text pixel generator.
// Depends on nothing.
`default_nettype none
package ptpg_pkg;

  localparam int GlyphRows  = 6;
  localparam int GlyphCols  = 5;
  localparam int GlyphBits  = GlyphRows * GlyphCols;
  localparam int QueueDepth = 2;

  localparam logic [7:0] CharSpace = 8'h20;

  typedef logic [GlyphBits-1:0] glyph_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       first_char;
    logic [7:0] x_origin;
    logic [7:0] y_origin;
    logic [7:0] draw_mode;
  } in_item_t;

  typedef struct packed {
    logic [7:0] pixel_x;
    logic [7:0] pixel_y;
    logic [7:0] pixel_mode;
    logic       glyph_last;
  } out_item_t;

  // One queued glyph: bitmap plus where and how to draw it
  typedef struct packed {
    glyph_t     bitmap;
    logic [7:0] base_x;
    logic [7:0] y_origin;
    logic [7:0] draw_mode;
  } glyph_job_t;

  // Row 0 is y+1, row 5 is y-4; bit c of a row is column c
  function automatic glyph_t pack_rows(input logic [4:0] r0, input logic [4:0] r1,
                                       input logic [4:0] r2, input logic [4:0] r3,
                                       input logic [4:0] r4, input logic [4:0] r5);
    return {r5, r4, r3, r2, r1, r0};
  endfunction

  function automatic glyph_t glyph_lookup(input logic [7:0] code);
    glyph_t g;
    unique case (code)
      "A": g = pack_rows(5'h00, 5'h09, 5'h09, 5'h0F, 5'h09, 5'h06);
      "B": g = pack_rows(5'h00, 5'h07, 5'h09, 5'h07, 5'h09, 5'h07);
      "C": g = pack_rows(5'h00, 5'h0E, 5'h01, 5'h01, 5'h01, 5'h0E);
      "D": g = pack_rows(5'h00, 5'h07, 5'h09, 5'h09, 5'h09, 5'h07);
      "E": g = pack_rows(5'h00, 5'h0F, 5'h01, 5'h07, 5'h01, 5'h0F);
      "F": g = pack_rows(5'h00, 5'h01, 5'h01, 5'h07, 5'h01, 5'h0F);
      "G": g = pack_rows(5'h00, 5'h0E, 5'h09, 5'h0D, 5'h01, 5'h0E);
      "H": g = pack_rows(5'h00, 5'h09, 5'h09, 5'h0F, 5'h09, 5'h09);
      "I": g = pack_rows(5'h00, 5'h02, 5'h02, 5'h02, 5'h02, 5'h02);
      "J": g = pack_rows(5'h00, 5'h06, 5'h09, 5'h09, 5'h08, 5'h08);
      "K": g = pack_rows(5'h00, 5'h09, 5'h05, 5'h03, 5'h05, 5'h09);
      "L": g = pack_rows(5'h00, 5'h0F, 5'h01, 5'h01, 5'h01, 5'h01);
      "M": g = pack_rows(5'h00, 5'h11, 5'h11, 5'h15, 5'h1B, 5'h11);
      "N": g = pack_rows(5'h00, 5'h09, 5'h09, 5'h0D, 5'h0B, 5'h09);
      "O": g = pack_rows(5'h00, 5'h06, 5'h09, 5'h09, 5'h09, 5'h06);
      "P": g = pack_rows(5'h00, 5'h01, 5'h01, 5'h07, 5'h09, 5'h07);
      "Q": g = pack_rows(5'h00, 5'h0E, 5'h0D, 5'h09, 5'h09, 5'h06);
      "R": g = pack_rows(5'h00, 5'h09, 5'h05, 5'h07, 5'h09, 5'h07);
      "S": g = pack_rows(5'h00, 5'h07, 5'h08, 5'h06, 5'h01, 5'h0E);
      "T": g = pack_rows(5'h00, 5'h02, 5'h02, 5'h02, 5'h02, 5'h07);
      "U": g = pack_rows(5'h00, 5'h0F, 5'h09, 5'h09, 5'h09, 5'h09);
      "V": g = pack_rows(5'h00, 5'h02, 5'h05, 5'h05, 5'h05, 5'h05);
      "W": g = pack_rows(5'h00, 5'h0A, 5'h15, 5'h11, 5'h11, 5'h11);
      "X": g = pack_rows(5'h00, 5'h05, 5'h05, 5'h02, 5'h05, 5'h05);
      "Y": g = pack_rows(5'h00, 5'h02, 5'h02, 5'h07, 5'h05, 5'h05);
      "Z": g = pack_rows(5'h00, 5'h0F, 5'h02, 5'h04, 5'h08, 5'h0F);
      ".": g = pack_rows(5'h00, 5'h02, 5'h00, 5'h00, 5'h00, 5'h00);
      ",": g = pack_rows(5'h02, 5'h02, 5'h00, 5'h00, 5'h00, 5'h00);
      "!": g = pack_rows(5'h00, 5'h02, 5'h00, 5'h02, 5'h02, 5'h02);
      "?": g = pack_rows(5'h00, 5'h02, 5'h00, 5'h06, 5'h08, 5'h06);
      "*": g = pack_rows(5'h00, 5'h04, 5'h15, 5'h0E, 5'h15, 5'h04);
      "/": g = pack_rows(5'h00, 5'h01, 5'h01, 5'h02, 5'h04, 5'h00);
      "+": g = pack_rows(5'h00, 5'h04, 5'h04, 5'h1F, 5'h04, 5'h04);
      "-": g = pack_rows(5'h00, 5'h00, 5'h00, 5'h0F, 5'h00, 5'h00);
      "=": g = pack_rows(5'h00, 5'h00, 5'h0F, 5'h00, 5'h0F, 5'h00);
      ":": g = pack_rows(5'h00, 5'h00, 5'h01, 5'h00, 5'h01, 5'h00);
      "1": g = pack_rows(5'h00, 5'h08, 5'h08, 5'h0A, 5'h0C, 5'h08);
      "2": g = pack_rows(5'h00, 5'h0F, 5'h02, 5'h04, 5'h09, 5'h06);
      "3": g = pack_rows(5'h00, 5'h06, 5'h09, 5'h04, 5'h09, 5'h06);
      "4": g = pack_rows(5'h00, 5'h08, 5'h08, 5'h0F, 5'h0A, 5'h0C);
      "5": g = pack_rows(5'h00, 5'h06, 5'h09, 5'h08, 5'h07, 5'h0F);
      "6": g = pack_rows(5'h00, 5'h06, 5'h09, 5'h07, 5'h02, 5'h04);
      "7": g = pack_rows(5'h00, 5'h01, 5'h02, 5'h04, 5'h08, 5'h0F);
      "8": g = pack_rows(5'h00, 5'h06, 5'h09, 5'h06, 5'h09, 5'h06);
      "9": g = pack_rows(5'h00, 5'h02, 5'h04, 5'h0E, 5'h09, 5'h06);
      "0": g = pack_rows(5'h00, 5'h06, 5'h09, 5'h09, 5'h09, 5'h06);
      default: g = '0;
    endcase
    return g;
  endfunction

  // Advance added after a given character
  function automatic logic [2:0] step_after(input logic [7:0] code);
    logic [2:0] s;
    unique case (code)
      CharSpace:                s = 3'd2;
      "I", "!", ".", ",", ":":  s = 3'd3;
      "T", "Y":                 s = 3'd4;
      "M", "W", "+", "*":       s = 3'd6;
      default:                  s = 3'd5;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

// File: hdl/ptpg_front.sv
// Front end: accepts characters, tracks the x advance, looks up the glyph.
// Depends on ptpg_pkg.
`default_nettype none
module ptpg_front (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire ptpg_pkg::in_item_t    in_item,
  input  wire logic                  q_full,
  output logic                       q_push,
  output ptpg_pkg::glyph_job_t       q_job
);

  logic [7:0]       advance_accum;
  logic [7:0]       previous_char;
  logic [7:0]       advance_next;
  logic             accept;
  ptpg_pkg::glyph_t bitmap;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign bitmap   = ptpg_pkg::glyph_lookup(in_item.char_code);

  always_comb begin
    if (in_item.first_char) begin
      advance_next = '0;
    end else begin
      advance_next = advance_accum + {5'd0, ptpg_pkg::step_after(previous_char)};
    end
  end

  // Drop spaces and unknown codes: nothing to draw
  assign q_push          = accept && (bitmap != '0);
  assign q_job.bitmap    = bitmap;
  assign q_job.base_x    = in_item.x_origin + advance_next;
  assign q_job.y_origin  = in_item.y_origin;
  assign q_job.draw_mode = in_item.draw_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      advance_accum <= '0;
      previous_char <= '0;
    end else if (accept) begin
      advance_accum <= advance_next;
      previous_char <= in_item.char_code;
    end
  end

endmodule
`default_nettype wire

// File: hdl/ptpg_queue.sv
// Two-entry queue of glyph jobs between front and back.
// Depends on ptpg_pkg.
`default_nettype none
module ptpg_queue (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  input  wire ptpg_pkg::glyph_job_t  push_job,
  output logic                       full,
  input  wire logic                  pop,
  output logic                       not_empty,
  output ptpg_pkg::glyph_job_t       head_job
);

  localparam int PtrW = (ptpg_pkg::QueueDepth > 1) ? $clog2(ptpg_pkg::QueueDepth) : 1;
  localparam int CntW = $clog2(ptpg_pkg::QueueDepth + 1);

  ptpg_pkg::glyph_job_t mem [ptpg_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign full      = (count == CntW'(ptpg_pkg::QueueDepth));
  assign not_empty = (count != '0);
  assign head_job  = mem[rd_ptr];

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(ptpg_pkg::QueueDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: hdl/ptpg_back.sv
// Back end: walks a glyph bitmap and emits one pixel write per cycle unless the output stalls.
// Depends on ptpg_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module ptpg_back (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  q_not_empty,
  input  wire ptpg_pkg::glyph_job_t  q_job,
  output logic                       q_pop,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output ptpg_pkg::out_item_t        out_item
);

  localparam int Rows = ptpg_pkg::GlyphRows;
  localparam int Cols = ptpg_pkg::GlyphCols;

  logic                 busy;
  ptpg_pkg::glyph_t     bits;
  ptpg_pkg::glyph_t     bits_next;
  ptpg_pkg::glyph_t     low_bit;
  logic [7:0]           base_x;
  logic [7:0]           y_origin;
  logic [7:0]           draw_mode;
  logic [Rows-1:0]      row_hit;
  logic [Cols-1:0]      col_hit;
  logic [2:0]           row_idx;
  logic [2:0]           col_idx;
  logic                 out_free;
  logic                 emit;

  // Isolate the lowest set bit: first pixel in descending y, ascending x
  assign low_bit   = bits & (~bits + 1'b1);
  assign bits_next = bits & ~low_bit;

  always_comb begin
    row_hit = '0;
    col_hit = '0;
    row_idx = '0;
    col_idx = '0;
    for (int r = 0; r < Rows; r++) begin
      row_hit[r] = |low_bit[r*Cols +: Cols];
      for (int c = 0; c < Cols; c++) begin
        col_hit[c] = col_hit[c] | low_bit[r*Cols + c];
      end
    end
    for (int r = 0; r < Rows; r++) begin
      if (row_hit[r]) row_idx = row_idx | 3'(r);
    end
    for (int c = 0; c < Cols; c++) begin
      if (col_hit[c]) col_idx = col_idx | 3'(c);
    end
  end

  assign out_free = !out_valid || out_ready;
  assign emit     = busy && out_free;
  assign q_pop    = !busy && q_not_empty;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      base_x    <= q_job.base_x;
      y_origin  <= q_job.y_origin;
      draw_mode <= q_job.draw_mode;
    end
    if (q_pop) begin
      bits <= q_job.bitmap;
    end else if (emit) begin
      bits <= bits_next;
    end
    if (emit) begin
      out_item.pixel_x    <= base_x + {5'd0, col_idx};
      out_item.pixel_y    <= y_origin + 8'd1 - {5'd0, row_idx};
      out_item.pixel_mode <= draw_mode;
      out_item.glyph_last <= (bits_next == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        busy <= 1'b1;
      end else if (emit && (bits_next == '0)) begin
        busy <= 1'b0;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `PTPG_ASSERT(a_busy_has_pixels, clk, rst, busy |-> (bits != '0), "busy with empty bitmap")
  `PTPG_NEVER(a_pop_while_busy, clk, rst, q_pop && busy, "job taken while drawing")
  `PTPG_ASSERT(a_last_ends_job, clk, rst, (emit && (bits_next == '0)) |=> (!busy && out_item.glyph_last), "last pixel did not end job")
  `PTPG_ASSERT(a_one_hot_pixel, clk, rst, busy |-> ($onehot(row_hit) && $onehot(col_hit)), "pixel select not one-hot")

endmodule
`default_nettype wire

// File: hdl/proportional_text_pixel_generator.sv
// Top level of the proportional text pixel generator.
// Depends on ptpg_pkg, ptpg_front, ptpg_queue, ptpg_back.
//
//   Channel | Handshake           | Payload
//   --------+---------------------+----------------------------------------
//   in      | in_valid, in_ready  | in_item: char, first flag, origin, mode
//   out     | out_valid, out_ready| out_item: pixel x, y, mode, last flag
//
// In the back end a character with n lit pixels first takes a load step, the
// glyph moved from the queue, then yields its n pixels, one per cycle, from the
// bitmap walker while the output is not stalled; the largest glyph has 13 pixels.
// Spaces and unknown codes are accepted at the front and yield no transfer.
// The front accepts while the two-entry glyph queue has room, so it runs ahead
// of the back end; an output stall holds the walker and then fills the queue.
// Reset (rst, synchronous) clears the advance, the previous character, the
// queue pointers and the output valid.
`default_nettype none
module proportional_text_pixel_generator (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire ptpg_pkg::in_item_t  in_item,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output ptpg_pkg::out_item_t      out_item
);

  ptpg_pkg::glyph_job_t push_job;
  ptpg_pkg::glyph_job_t head_job;
  logic                 q_push;
  logic                 q_full;
  logic                 q_pop;
  logic                 q_not_empty;

  // Front: advance tracking and glyph lookup; push drawable characters
  ptpg_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (push_job)
  );

  // Queue: decouple lookup from pixel emission
  ptpg_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_job  (push_job),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_job  (head_job)
  );

  // Back: walk the bitmap, one pixel transfer per cycle unless the output stalls
  ptpg_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_job       (head_job),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_item    (out_item)
  );

endmodule
`default_nettype wire
